/* rtl/core/elv_pkg.sv */
// Shared types and constants for the elevation grid bilinear sampler.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package elv_pkg;

  localparam int GRID_W   = 12;  // grid_points field width
  localparam int FRAC_W   = 24;  // fraction bits of query coordinates
  localparam int SAMPLE_W = 16;  // height sample width
  localparam int HEIGHT_W = 24;  // result height width
  localparam int OUT_DEPTH = 8;  // result queue depth
  localparam int OUT_PW    = 3;  // result queue pointer width
  localparam int OUT_CW    = 4;  // result queue / in-flight count width

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  // Read beat that travels with the registered memory data.
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic              last;
    logic [1:0]        idx;
    logic [FRAC_W-1:0] ty;
    logic [FRAC_W-1:0] tx;
  } rd_beat_t;

endpackage

`default_nettype wire

/* rtl/core/elevation_grid_bilinear_sampler.sv */
// Top level of the elevation grid bilinear sampler: command stage, slot headers,
// address stage, read sequencer and result queue. Uses elv_pkg, elv_sample_mem, elv_interp.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s_*     | in  | slot, corner_lat, corner_lon, grid_points,      | command
//          |     | sample_index, sample_value, query_lat, query_lon|
//  m_*     | out | height_out                                      | found
//
// A header or sample item completes in the command stage; a query makes four reads of the
// single sample memory port, one per neighbor; the next query loads on the last read.
// A query with no matching slot makes no reads.
// A sample write waits until every earlier query has finished its reads.
// Reset clears slot valid marks and all control; sample memory is not cleared.
// Results queue in eight entries; with m_tready low, eight queries in flight hold the
// address stage, and once the command stage behind it fills the input stalls.
`default_nettype none

module elevation_grid_bilinear_sampler #(
  parameter int TILE_SLOTS      = 4,
  parameter int MAX_GRID_POINTS = 3601
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // slot[1:0] corner_lat[9:2] corner_lon[18:10] grid_points[30:19] sample_index[54:31]
  // sample_value[70:55] query_lat[102:71] query_lon[135:103]
  input  wire logic [135:0] s_tdata,
  // command[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // height_out[23:0]
  output logic [23:0]       m_tdata,
  // found[0]
  output logic              m_tuser
);
  import elv_pkg::*;

  localparam int SLOT_SAMPLES = MAX_GRID_POINTS * MAX_GRID_POINTS;
  localparam int DEPTH        = TILE_SLOTS * SLOT_SAMPLES;
  localparam int AW           = $clog2(DEPTH);
  localparam int KW           = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1;

  // ---------------- command stage ----------------
  logic                 s1_valid;
  cmd_t                 s1_cmd;
  logic [1:0]           s1_slot;
  logic signed [7:0]    s1_clat;
  logic signed [8:0]    s1_clon;
  logic [GRID_W-1:0]    s1_grid;
  logic [23:0]          s1_idx;
  logic signed [15:0]   s1_val;
  logic [31:0]          s1_qlat;
  logic [32:0]          s1_qlon;
  logic                 s1_adv;

  // ---------------- slot headers ----------------
  logic                 slot_valid [TILE_SLOTS];
  logic signed [7:0]    slot_clat  [TILE_SLOTS];
  logic signed [8:0]    slot_clon  [TILE_SLOTS];
  logic [GRID_W-1:0]    slot_grid  [TILE_SLOTS];

  // ---------------- address stage ----------------
  logic                 s2_valid, s2_hit, s2_adv;
  logic [KW-1:0]        s2_k;
  logic [GRID_W-1:0]    s2_g;
  logic [12:0]          s2_r0;
  logic [GRID_W-1:0]    s2_c0;
  logic [FRAC_W-1:0]    s2_ty, s2_tx;

  // ---------------- read sequencer ----------------
  logic                 seq_active, seq_hit, seq_last, seq_free;
  logic [1:0]           seq_cnt;
  logic [AW-1:0]        seq_addr [4];
  logic [FRAC_W-1:0]    seq_ty, seq_tx;
  rd_beat_t             beat;

  // ---------------- memory port ----------------
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_addr, waddr;
  logic signed [15:0]   mem_rdata;

  // ---------------- result queue ----------------
  logic                 res_valid, res_found;
  logic [HEIGHT_W-1:0]  res_height;
  logic [HEIGHT_W-1:0]  q_height [OUT_DEPTH];
  logic                 q_found  [OUT_DEPTH];
  logic [OUT_PW-1:0]    q_wr, q_rd;
  logic [OUT_CW-1:0]    q_count, inflight;
  logic                 pop;

  // ---------------- combinational helpers ----------------
  logic [KW+1:0]        slot_ext;
  logic                 slot_ok, idx_ok;
  logic [GRID_W-1:0]    hdr_grid;
  logic                 m_hit;
  logic [KW-1:0]        m_k;
  logic [GRID_W-1:0]    m_g, m_g1;
  logic [24:0]          one_minus;
  logic [36:0]          v;
  logic [35:0]          fx;
  logic [GRID_W-1:0]    a_g1, rr0, rr1, cc0, cc1;
  logic [12:0]          r1w;
  logic [23:0]          base0, base1;
  logic [AW-1:0]        sbase;

  assign s_tready = !s1_valid || s1_adv;

  // accept an item into the command stage
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_cmd  <= cmd_t'(s_tuser);
      s1_slot <= s_tdata[1:0];
      s1_clat <= s_tdata[9:2];
      s1_clon <= s_tdata[18:10];
      s1_grid <= s_tdata[30:19];
      s1_idx  <= s_tdata[54:31];
      s1_val  <= s_tdata[70:55];
      s1_qlat <= s_tdata[102:71];
      s1_qlon <= s_tdata[135:103];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // advance rules: a sample write waits for every earlier read to drain
  always_comb begin
    case (s1_cmd)
      CMD_SAMPLE: s1_adv = s1_valid && !s2_valid && !seq_active;
      CMD_QUERY:  s1_adv = s1_valid && (!s2_valid || s2_adv);
      default:    s1_adv = s1_valid;
    endcase
  end

  always_comb begin
    slot_ext = (KW + 2)'(s1_slot);
    slot_ok  = (32'(slot_ext) < 32'(TILE_SLOTS));
    idx_ok   = ({8'd0, s1_idx} < 32'(SLOT_SAMPLES));
    if (s1_grid < 12'd2) begin
      hdr_grid = 12'd2;
    end else if ({20'd0, s1_grid} > 32'(MAX_GRID_POINTS)) begin
      hdr_grid = GRID_W'(MAX_GRID_POINTS);
    end else begin
      hdr_grid = s1_grid;
    end
    waddr  = AW'(slot_ext[KW-1:0]) * AW'(SLOT_SAMPLES) + AW'(s1_idx);
    mem_we = s1_adv && (s1_cmd == CMD_SAMPLE) && slot_ok && idx_ok;
  end

  // header write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TILE_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        slot_clat[i]  <= '0;
        slot_clon[i]  <= '0;
        slot_grid[i]  <= '0;
      end
    end else if (s1_adv && (s1_cmd == CMD_HEADER) && slot_ok) begin
      slot_valid[slot_ext[KW-1:0]] <= 1'b1;
      slot_clat[slot_ext[KW-1:0]]  <= s1_clat;
      slot_clon[slot_ext[KW-1:0]]  <= s1_clon;
      slot_grid[slot_ext[KW-1:0]]  <= hdr_grid;
    end
  end

  // slot match, lowest slot wins; scale fractions by the grid span
  always_comb begin
    m_hit = 1'b0;
    m_k   = '0;
    for (int i = TILE_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && (slot_clat[i] == $signed(s1_qlat[31:24])) &&
          (slot_clon[i] == $signed(s1_qlon[32:24]))) begin
        m_hit = 1'b1;
        m_k   = KW'(i);
      end
    end
    m_g       = slot_grid[m_k];
    m_g1      = m_g - 12'd1;
    one_minus = 25'h1000000 - {1'b0, s1_qlat[23:0]};
    v         = 37'(one_minus) * 37'(m_g1);
    fx        = 36'(s1_qlon[23:0]) * 36'(m_g1);
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_cmd == CMD_QUERY)) begin
      s2_hit <= m_hit;
      s2_k   <= m_k;
      s2_g   <= m_g;
      s2_r0  <= v[36:24];
      s2_ty  <= v[23:0];
      s2_c0  <= fx[35:24];
      s2_tx  <= fx[23:0];
    end
  end

  assign seq_last = seq_active && (!seq_hit || (seq_cnt == 2'd3));
  assign seq_free = !seq_active || seq_last;
  assign s2_adv   = s2_valid && seq_free && (inflight < OUT_CW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv && (s1_cmd == CMD_QUERY)) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  // clamp rows and columns to the grid, then form the four addresses
  always_comb begin
    a_g1  = s2_g - 12'd1;
    r1w   = s2_r0 + 13'd1;
    rr0   = (s2_r0 > {1'b0, a_g1}) ? a_g1 : s2_r0[GRID_W-1:0];
    rr1   = (r1w > {1'b0, a_g1}) ? a_g1 : r1w[GRID_W-1:0];
    cc0   = (s2_c0 > a_g1) ? a_g1 : s2_c0;
    cc1   = (s2_c0 >= a_g1) ? a_g1 : s2_c0 + 12'd1;
    base0 = 24'(rr0) * 24'(s2_g);
    base1 = (rr1 == rr0) ? base0 : base0 + 24'(s2_g);
    sbase = AW'(s2_k) * AW'(SLOT_SAMPLES);
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      seq_hit     <= s2_hit;
      seq_ty      <= s2_ty;
      seq_tx      <= s2_tx;
      seq_addr[0] <= sbase + AW'(base0) + AW'(cc0);
      seq_addr[1] <= sbase + AW'(base1) + AW'(cc0);
      seq_addr[2] <= sbase + AW'(base0) + AW'(cc1);
      seq_addr[3] <= sbase + AW'(base1) + AW'(cc1);
    end
  end

  // one read per cycle; load the next query on the last read
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active <= 1'b0;
      seq_cnt    <= 2'd0;
    end else if (s2_adv) begin
      seq_active <= 1'b1;
      seq_cnt    <= 2'd0;
    end else if (seq_last) begin
      seq_active <= 1'b0;
    end else if (seq_active) begin
      seq_cnt <= seq_cnt + 2'd1;
    end
  end

  assign mem_re   = seq_active && seq_hit;
  assign mem_addr = mem_we ? waddr : seq_addr[seq_cnt];

  // tag travels alongside the registered read data
  always_ff @(posedge clk) begin
    beat.hit  <= seq_hit;
    beat.last <= seq_last;
    beat.idx  <= seq_cnt;
    beat.ty   <= seq_ty;
    beat.tx   <= seq_tx;
    if (rst) begin
      beat.valid <= 1'b0;
    end else begin
      beat.valid <= seq_active;
    end
  end

  elv_sample_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (s1_val),
    .rdata (mem_rdata)
  );

  elv_interp u_interp (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .rdata      (mem_rdata),
    .out_valid  (res_valid),
    .out_height (res_height),
    .out_found  (res_found)
  );

  // result queue; in-flight count keeps it from overflowing
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (q_count != '0);
  assign m_tdata  = q_height[q_rd];
  assign m_tuser  = q_found[q_rd];

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q_height[q_wr] <= res_height;
      q_found[q_wr]  <= res_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr     <= '0;
      q_rd     <= '0;
      q_count  <= '0;
      inflight <= '0;
    end else begin
      if (res_valid) begin
        q_wr <= q_wr + OUT_PW'(1);
      end
      if (pop) begin
        q_rd <= q_rd + OUT_PW'(1);
      end
      q_count  <= q_count + OUT_CW'(res_valid) - OUT_CW'(pop);
      inflight <= inflight + OUT_CW'(s2_adv) - OUT_CW'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("sample write collides with a query read");

  a_inflight_cap: assert property (@(posedge clk) disable iff (rst)
    inflight <= OUT_CW'(OUT_DEPTH))
    else $error("too many queries in flight");

  a_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_valid && (q_count == OUT_CW'(OUT_DEPTH)) && !pop))
    else $error("result queue overflow");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= inflight)
    else $error("queue holds more results than queries in flight");
`endif

endmodule

`default_nettype wire

/* rtl/core/elv_sample_mem.sv */
// Single-port sample memory with registered read data.
// Depends on elv_pkg for the sample width.
`default_nettype none

module elv_sample_mem #(
  parameter int DEPTH = 51868804,
  parameter int AW    = 26
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic                            re,
  input  wire logic [AW-1:0]                   addr,
  input  wire logic signed [elv_pkg::SAMPLE_W-1:0] wdata,
  output logic signed [elv_pkg::SAMPLE_W-1:0]      rdata
);
  import elv_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/elv_interp.sv */
// Bilinear interpolation pipeline: collects four samples, then four stages.
// Depends on elv_pkg for rd_beat_t and widths.
`default_nettype none

module elv_interp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire elv_pkg::rd_beat_t                   beat,
  input  wire logic signed [elv_pkg::SAMPLE_W-1:0] rdata,
  output logic                                     out_valid,
  output logic [elv_pkg::HEIGHT_W-1:0]             out_height,
  output logic                                     out_found
);
  import elv_pkg::*;

  logic signed [SAMPLE_W-1:0] h00, h10, h01;

  logic                       p1_valid, p1_hit;
  logic signed [SAMPLE_W-1:0] p1_h00, p1_h01;
  logic signed [SAMPLE_W:0]   p1_dy0, p1_dy1;
  logic [FRAC_W-1:0]          p1_ty, p1_tx;

  logic               p2_valid, p2_hit;
  logic signed [41:0] p2_h0, p2_h1;
  logic [FRAC_W-1:0]  p2_tx;

  logic               p3_valid, p3_hit;
  logic signed [41:0] p3_h0;
  logic signed [46:0] p3_phi;
  logic [44:0]        p3_plo;

  logic signed [41:0] m0, m1, h0c, h1c;
  logic signed [42:0] d;
  logic signed [46:0] phi;
  logic [44:0]        plo;
  logic signed [67:0] hsum;

  // capture the first three samples of a query
  always_ff @(posedge clk) begin
    if (beat.valid && beat.hit) begin
      case (beat.idx)
        2'd0:    h00 <= rdata;
        2'd1:    h10 <= rdata;
        2'd2:    h01 <= rdata;
        default: h00 <= h00;
      endcase
    end
  end

  always_comb begin
    m0  = $signed(p1_dy0) * $signed({1'b0, p1_ty});
    m1  = $signed(p1_dy1) * $signed({1'b0, p1_ty});
    h0c = $signed({{2{p1_h00[SAMPLE_W-1]}}, p1_h00, 24'd0}) + m0;
    h1c = $signed({{2{p1_h01[SAMPLE_W-1]}}, p1_h01, 24'd0}) + m1;
    d   = $signed({p2_h1[41], p2_h1}) - $signed({p2_h0[41], p2_h0});
    phi = $signed(d[42:21]) * $signed({1'b0, p2_tx});
    plo = 45'(d[20:0]) * 45'(p2_tx);
    hsum = $signed({{2{p3_h0[41]}}, p3_h0, 24'd0}) + $signed({p3_phi, 21'd0})
         + $signed({23'd0, p3_plo});
  end

  always_ff @(posedge clk) begin
    p1_h00 <= h00;
    p1_h01 <= h01;
    p1_dy0 <= 17'(h10) - 17'(h00);
    p1_dy1 <= 17'(rdata) - 17'(h01);
    p1_ty  <= beat.ty;
    p1_tx  <= beat.tx;
    p1_hit <= beat.hit;
    p2_h0  <= h0c;
    p2_h1  <= h1c;
    p2_tx  <= p1_tx;
    p2_hit <= p1_hit;
    p3_h0  <= p2_h0;
    p3_phi <= phi;
    p3_plo <= plo;
    p3_hit <= p2_hit;
    out_height <= p3_hit ? hsum[63:40] : '0;
    out_found  <= p3_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_valid  <= beat.valid && beat.last;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      out_valid <= p3_valid;
    end
  end

endmodule

`default_nettype wire
